@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PWPE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the block's clk_i and rst_ni.
`define PWPE_ASSERT(lbl, prop, msg) \
  `PWPE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hw/rtl/pwpe_pkg.sv @@
// Package for the weighted phase estimate block: widths, codes, FSM states,
// and the command/status structs between controller and datapath. No dependencies.
package pwpe_pkg;

  localparam int unsigned CONF_BITS = 16;

  localparam int unsigned WeightW  = 8;
  localparam int unsigned ConfW    = 16;
  localparam int unsigned PhaseW   = 16;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CsumW    = 32;
  localparam int unsigned PsumW    = 48;
  localparam int unsigned ResW     = 24;
  localparam int unsigned DvdW     = PsumW + 8;
  localparam int unsigned CntW     = $clog2(DvdW);
  localparam int unsigned DrainCycles = 4;

  typedef enum logic [1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_CLIP         = 2'd1,
    CFG_WEIGHT_TOTAL = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_LOAD,
    ST_PH_INIT,
    ST_PH_DIV,
    ST_CF_INIT,
    ST_CF_DIV,
    ST_CF_STORE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic cell_take;
    logic acc_load;
    logic div_init;
    logic div_conf;
    logic div_step;
    logic store_phase;
    logic store_conf;
  } pwpe_cmd_t;

  typedef struct packed {
    logic est_valid;
  } pwpe_sts_t;

endpackage

@@ hw/rtl/pwpe_ctrl.sv @@
// Controller FSM: takes cells, drains the accumulate pipeline, sequences the
// two divisions when the estimate is valid and strobes the result. Depends on pwpe_pkg.
module pwpe_ctrl
  import pwpe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      last_cell_i,
  input  pwpe_sts_t sts_i,
  output pwpe_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o          = 1'b0;
        cmd_o.cell_take = start_i;
        if (start_i && last_cell_i) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        if (cnt_q == CntW'(DrainCycles - 1)) begin
          state_d = ST_LOAD;
        end else begin
          cnt_d = CntW'(cnt_q + 1'b1);
        end
      end
      ST_LOAD: begin
        cmd_o.acc_load = 1'b1;
        state_d = sts_i.est_valid ? ST_PH_INIT : ST_EMIT;
      end
      ST_PH_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = ST_PH_DIV;
      end
      ST_PH_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntW'(DvdW - 1)) begin
          state_d = ST_CF_INIT;
        end else begin
          cnt_d = CntW'(cnt_q + 1'b1);
        end
      end
      ST_CF_INIT: begin
        cmd_o.store_phase = 1'b1;
        cmd_o.div_init    = 1'b1;
        cmd_o.div_conf    = 1'b1;
        cnt_d   = '0;
        state_d = ST_CF_DIV;
      end
      ST_CF_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_conf = 1'b1;
        if (cnt_q == CntW'(DvdW - 1)) begin
          state_d = ST_CF_STORE;
        end else begin
          cnt_d = CntW'(cnt_q + 1'b1);
        end
      end
      ST_CF_STORE: begin
        cmd_o.store_conf = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/pwpe_datapath.sv @@
// Datapath: config registers, cell pipeline with the two accumulators, shared
// restoring divider and result registers. Depends on pwpe_pkg.
module pwpe_datapath
  import pwpe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic [WeightW-1:0]       cell_weight_i,
  input  logic [ConfW-1:0]         cell_confidence_i,
  input  logic signed [PhaseW-1:0] cell_phase_i,
  input  pwpe_cmd_t                cmd_i,
  output pwpe_sts_t                sts_o,
  output logic                     estimate_valid_o,
  output logic signed [ResW-1:0]   mean_phase_q8_o,
  output logic [ResW-1:0]          mean_confidence_q8_o
);

  localparam int unsigned ConfMaskW = (CONF_BITS < ConfW) ? CONF_BITS : ConfW;
  localparam logic [ConfW-1:0] ConfMask = ConfW'((33'd1 << ConfMaskW) - 33'd1);
  localparam int unsigned WpW   = WeightW + PhaseW + 1;
  localparam int unsigned ProdW = WpW + ConfW;

  // configuration
  logic [CfgW-1:0] thr_q, clip_q, wt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= CfgW'(16);
      clip_q <= CfgW'(512);
      wt_q   <= CfgW'(768);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:    thr_q  <= cfg_data_i;
        CFG_CLIP:         clip_q <= cfg_data_i;
        CFG_WEIGHT_TOTAL: wt_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // cell pipeline; weight forced to zero for cells that do not count
  logic [ConfW-1:0] c_m, c_clip, off, b_c1_d, b_c2_d;
  logic             take;
  logic [WeightW-1:0]     a_w_q, b_w_q;
  logic [ConfW-1:0]       a_c_q, b_c1_q, b_c2_q, c_c2_q;
  logic signed [PhaseW-1:0] a_p_q, b_p_q;
  logic [WeightW+ConfW-1:0] wc1, c_wc1_q;
  logic signed [WpW-1:0]  wp, c_wp_q;
  logic signed [ProdW-1:0] prod, prod_q;
  logic [CsumW-1:0]       csum_q;
  logic [PsumW-1:0]       psum_q;

  assign c_m    = cell_confidence_i & ConfMask;
  assign take   = cmd_i.cell_take && (cell_weight_i != '0) && (c_m >= thr_q);
  assign c_clip = (c_m > clip_q) ? clip_q : c_m;
  assign off    = thr_q >> 2;
  assign b_c1_d = (a_c_q > off) ? ConfW'(a_c_q - off) : '0;
  assign b_c2_d = (b_c1_d > off) ? ConfW'(b_c1_d - off) : '0;
  assign wc1    = {{ConfW{1'b0}}, b_w_q} * {{WeightW{1'b0}}, b_c1_q};
  assign wp     = $signed({{(WpW-WeightW){1'b0}}, b_w_q})
                * $signed({{(WpW-PhaseW){b_p_q[PhaseW-1]}}, b_p_q});
  assign prod   = c_wp_q * $signed({1'b0, c_c2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_w_q   <= '0;
      a_c_q   <= '0;
      a_p_q   <= '0;
      b_w_q   <= '0;
      b_p_q   <= '0;
      b_c1_q  <= '0;
      b_c2_q  <= '0;
      c_wc1_q <= '0;
      c_wp_q  <= '0;
      c_c2_q  <= '0;
      prod_q  <= '0;
      csum_q  <= '0;
      psum_q  <= '0;
    end else begin
      a_w_q   <= take ? cell_weight_i : '0;
      a_c_q   <= c_clip;
      a_p_q   <= cell_phase_i;
      b_w_q   <= a_w_q;
      b_p_q   <= a_p_q;
      b_c1_q  <= b_c1_d;
      b_c2_q  <= b_c2_d;
      c_wc1_q <= wc1;
      c_wp_q  <= wp;
      c_c2_q  <= b_c2_q;
      prod_q  <= prod;
      if (cmd_i.acc_load) begin
        csum_q <= '0;
        psum_q <= '0;
      end else begin
        csum_q <= CsumW'(csum_q + {{(CsumW-WeightW-ConfW){1'b0}}, c_wc1_q});
        psum_q <= PsumW'(psum_q + {{(PsumW-ProdW){prod_q[ProdW-1]}}, prod_q});
      end
    end
  end

  assign sts_o.est_valid = (wt_q != '0) && ({{(CsumW-CfgW){1'b0}}, wt_q} <= csum_q);

  // frame snapshot and shared restoring divider (quotient shifts into dvd_q)
  logic [CsumW-1:0] swc_q;
  logic [PsumW-1:0] sp_q, mag;
  logic [DvdW-1:0]  dvd_q;
  logic [CsumW-1:0] dsr_q, rem_q;
  logic [CsumW:0]   rem_sh;
  logic             ge;

  assign mag    = sp_q[PsumW-1] ? PsumW'(~sp_q + 1'b1) : sp_q;
  assign rem_sh = {rem_q, dvd_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) begin
      swc_q <= csum_q;
      sp_q  <= psum_q;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      if (cmd_i.div_conf) begin
        dvd_q <= {{(DvdW-CsumW-8){1'b0}}, swc_q, 8'd0};
        dsr_q <= {{(CsumW-CfgW){1'b0}}, wt_q};
      end else begin
        dvd_q <= {mag, 8'd0};
        dsr_q <= swc_q;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? CsumW'(rem_sh - {1'b0, dsr_q}) : rem_sh[CsumW-1:0];
      dvd_q <= {dvd_q[DvdW-2:0], ge};
    end
  end

  // result registers
  localparam logic [DvdW-1:0] NegLim = DvdW'(24'h800000);
  localparam logic [DvdW-1:0] PosLim = DvdW'(24'h7FFFFF);
  localparam logic [DvdW-1:0] UnsLim = DvdW'(24'hFFFFFF);

  logic [ResW-1:0] ph_mag;
  logic [ResW-1:0] ph_res;
  logic [ResW-1:0] cf_res;

  always_comb begin
    if (sp_q[PsumW-1]) begin
      ph_mag = (dvd_q > NegLim) ? ResW'(NegLim) : dvd_q[ResW-1:0];
      ph_res = ResW'(~ph_mag + 1'b1);
    end else begin
      ph_mag = (dvd_q > PosLim) ? ResW'(PosLim) : dvd_q[ResW-1:0];
      ph_res = ph_mag;
    end
    cf_res = (dvd_q > UnsLim) ? ResW'(UnsLim) : dvd_q[ResW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estimate_valid_o     <= 1'b0;
      mean_phase_q8_o      <= '0;
      mean_confidence_q8_o <= '0;
    end else begin
      if (cmd_i.acc_load) begin
        estimate_valid_o     <= sts_o.est_valid;
        mean_phase_q8_o      <= '0;
        mean_confidence_q8_o <= '0;
      end
      if (cmd_i.store_phase) begin
        mean_phase_q8_o <= $signed(ph_res);
      end
      if (cmd_i.store_conf) begin
        mean_confidence_q8_o <= cf_res;
      end
    end
  end

endmodule

@@ hw/rtl/pdaf_weighted_phase_estimate.sv @@
// Non-last cells: one per cycle, busy_o stays low. A last cell raises busy_o; the strobe
// done_o follows the drain, the frame load and, when the estimate is valid, the two passes
// of the 56-step restoring divider. busy_o falls after the strobe cycle.
// The receiver cannot stall: each result shows for one cycle with done_o.
// Reset (rst_ni low, asynchronous) clears accumulators, pipeline and FSM and loads
// the register defaults; no clearing pass is needed.
module pdaf_weighted_phase_estimate
  import pwpe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [WeightW-1:0]       cell_weight_i,
  input  logic [ConfW-1:0]         cell_confidence_i,
  input  logic signed [PhaseW-1:0] cell_phase_i,
  input  logic                     last_cell_i,
  output logic                     done_o,
  output logic                     estimate_valid_o,
  output logic signed [ResW-1:0]   mean_phase_q8_o,
  output logic [ResW-1:0]          mean_confidence_q8_o
);

  pwpe_cmd_t cmd;
  pwpe_sts_t sts;

  pwpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_cell_i (last_cell_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  pwpe_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .cell_weight_i        (cell_weight_i),
    .cell_confidence_i    (cell_confidence_i),
    .cell_phase_i         (cell_phase_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .estimate_valid_o     (estimate_valid_o),
    .mean_phase_q8_o      (mean_phase_q8_o),
    .mean_confidence_q8_o (mean_confidence_q8_o)
  );

endmodule

@@ hw/rtl/pwpe_checker.sv @@
// Port-level checker for pdaf_weighted_phase_estimate, bound to the top level.
// Depends on pwpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwpe_checker
  import pwpe_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     last_cell_i,
  input logic                     done_o,
  input logic                     estimate_valid_o,
  input logic signed [ResW-1:0]   mean_phase_q8_o,
  input logic [ResW-1:0]          mean_confidence_q8_o
);

  `PWPE_ASSERT(a_done_busy, done_o |-> busy_o, "result strobe while idle")
  `PWPE_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `PWPE_ASSERT(a_mid_idle, (start_i && !busy_o && !last_cell_i) |=> !busy_o, "busy after mid-frame transaction")
  `PWPE_ASSERT(a_last_busy, (start_i && !busy_o && last_cell_i) |=> busy_o, "not busy after last cell")
  `PWPE_ASSERT(a_invalid_zero, (done_o && !estimate_valid_o) |-> (mean_phase_q8_o == '0 && mean_confidence_q8_o == '0), "invalid estimate with nonzero means")

endmodule

bind pdaf_weighted_phase_estimate pwpe_checker u_pwpe_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .start_i              (start_i),
  .busy_o               (busy_o),
  .last_cell_i          (last_cell_i),
  .done_o               (done_o),
  .estimate_valid_o     (estimate_valid_o),
  .mean_phase_q8_o      (mean_phase_q8_o),
  .mean_confidence_q8_o (mean_confidence_q8_o)
);
